// ----- src/vp8_rtp_depacketizer_unit_assert.svh -----
// Assertion macros used by the checker file.
`ifndef VP8_RTP_DEPACKETIZER_UNIT_ASSERT_SVH
`define VP8_RTP_DEPACKETIZER_UNIT_ASSERT_SVH

// Same-cycle implication, gated off while reset is asserted.
`define VP8_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, gated off while reset is asserted.
`define VP8_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- src/vp8rtp_pkg.sv -----
package vp8rtp_pkg;

  localparam int unsigned MAX_PACKET_LENGTH = 2047;
  localparam int unsigned PLEN_W = 11;
  localparam int unsigned TS_W = 32;

  // Payload descriptor byte 0
  localparam logic [7:0] DESC_X_MASK   = 8'h80;
  localparam logic [7:0] DESC_S_MASK   = 8'h10;
  localparam logic [7:0] DESC_PID_MASK = 8'h07;
  // Extension byte
  localparam logic [7:0] EXT_I_MASK  = 8'h80;
  localparam logic [7:0] EXT_L_MASK  = 8'h40;
  localparam logic [7:0] EXT_TK_MASK = 8'h30;
  // PictureID byte: M bit selects a 15-bit PictureID
  localparam logic [7:0] PID_M_MASK  = 8'h80;

  // Fewest payload bytes a partition-0 frame start may carry
  localparam int unsigned MIN_FRAME_START = 3;

  typedef struct packed {
    logic [7:0]        data_byte;
    logic              packet_start;
    logic [PLEN_W-1:0] packet_length;
    logic [TS_W-1:0]   rtp_timestamp;
    logic              marker;
  } in_t;

  typedef struct packed {
    logic [7:0]      out_byte;
    logic            byte_valid;
    logic            frame_end;
    logic [TS_W-1:0] frame_timestamp;
    logic            frame_discard;
    logic            packet_error;
  } out_t;

endpackage

// ----- src/vp8_rtp_depacketizer_unit.sv -----
// VP8 RTP depacketizer. Takes the RTP payload one byte per transfer, descriptor
// first; packet length, timestamp and marker ride on the packet's first byte.
// Each input transfer yields exactly one output transfer: a frame byte
// (byte_valid), and/or frame_end with the finished frame's timestamp,
// frame_discard when a partition-0 start drops an unfinished frame, or
// packet_error when the descriptor is truncated or a frame start carries fewer
// than 3 payload bytes (the rest of that packet is then ignored). Descriptor
// bytes (X, I, M, L, T/K) are consumed silently. Throughput is one byte per
// clock while in_stall_o is low. The result register after the combinational
// parser gives each result in the cycle after its byte is taken; in_stall_o
// rises only while it is full and out_stall_i is high, so input keeps flowing
// whenever the output drains. Lengths above MaxPacketLength are clipped to it.
module vp8_rtp_depacketizer_unit #(
  parameter int unsigned MaxPacketLength = vp8rtp_pkg::MAX_PACKET_LENGTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  vp8rtp_pkg::in_t  in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output vp8rtp_pkg::out_t out_data_o
);

  logic             take;
  logic             out_valid_q;
  vp8rtp_pkg::out_t out_data_q;
  vp8rtp_pkg::out_t res;

  // Result register full and held: hold off new bytes
  assign in_stall_o = out_valid_q && out_stall_i;
  assign take       = in_valid_i && !in_stall_o;

  vp8rtp_core #(
    .MaxPacketLength(MaxPacketLength)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .take_i  (take),
    .item_i  (in_data_i),
    .result_o(res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk_i) begin
    if (take) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ----- src/vp8rtp_core.sv -----
module vp8rtp_core #(
  parameter int unsigned MaxPacketLength = vp8rtp_pkg::MAX_PACKET_LENGTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             take_i,
  input  vp8rtp_pkg::in_t  item_i,
  output vp8rtp_pkg::out_t result_o
);

  localparam int unsigned BlW = $clog2(MaxPacketLength + 1);

  // PhPayload out of a descriptor phase means "descriptor done"
  typedef enum logic [2:0] {
    PhWait, PhFirst, PhX, PhI, PhM, PhL, PhTk, PhPayload
  } phase_e;

  function automatic phase_e ext_next(input logic [7:0] flags, input logic [1:0] level);
    phase_e nx;
    if (level == 2'd0 && (flags & vp8rtp_pkg::EXT_I_MASK) != 8'h00) begin
      nx = PhI;
    end else if (level <= 2'd1 && (flags & vp8rtp_pkg::EXT_L_MASK) != 8'h00) begin
      nx = PhL;
    end else if ((flags & vp8rtp_pkg::EXT_TK_MASK) != 8'h00) begin
      nx = PhTk;
    end else begin
      nx = PhPayload;
    end
    return nx;
  endfunction

  phase_e                          phase_q, phase_d;
  logic [vp8rtp_pkg::TS_W-1:0]     dec_ts_q, dec_ts_d;
  logic [vp8rtp_pkg::TS_W-1:0]     cur_ts_q, cur_ts_d;
  logic                            nonempty_q, nonempty_d;
  logic [7:0]                      ext_q, ext_d;
  logic [7:0]                      fdb_q, fdb_d;
  logic [BlW-1:0]                  left_q, left_d;
  logic                            marker_q, marker_d;

  phase_e           nxt;
  logic             finish;
  logic             done;
  logic [7:0]       d;
  vp8rtp_pkg::out_t res;

  assign d = item_i.data_byte;

  always_comb begin
    phase_d    = phase_q;
    dec_ts_d   = dec_ts_q;
    cur_ts_d   = cur_ts_q;
    nonempty_d = nonempty_q;
    ext_d      = ext_q;
    fdb_d      = fdb_q;
    left_d     = left_q;
    marker_d   = marker_q;
    nxt        = PhWait;
    finish     = 1'b0;
    done       = 1'b0;
    res        = '0;

    if (take_i && item_i.packet_start) begin
      // timestamp change closes the buffered frame, valid packet or not
      if (item_i.rtp_timestamp != dec_ts_d) begin
        dec_ts_d = item_i.rtp_timestamp;
        if (nonempty_d) begin
          res.frame_end       = 1'b1;
          res.frame_timestamp = cur_ts_d;
          nonempty_d          = 1'b0;
        end
      end
      cur_ts_d = item_i.rtp_timestamp;
      marker_d = item_i.marker;
      if (32'(item_i.packet_length) > 32'(MaxPacketLength)) begin
        left_d = BlW'(MaxPacketLength);
      end else begin
        left_d = BlW'(item_i.packet_length);
      end
      phase_d = PhFirst;
      if (left_d == '0) begin
        res.packet_error = 1'b1;
        phase_d          = PhWait;
      end
    end

    if (take_i && phase_d != PhWait) begin
      left_d = left_d - BlW'(1);
      unique case (phase_d)
        PhWait:  nxt = PhWait;
        PhFirst: begin
          fdb_d = d;
          ext_d = '0;
          nxt   = ((d & vp8rtp_pkg::DESC_X_MASK) != 8'h00) ? PhX : PhPayload;
        end
        PhX: begin
          ext_d = d;
          nxt   = ext_next(d, 2'd0);
        end
        PhI:  nxt = ((d & vp8rtp_pkg::PID_M_MASK) != 8'h00) ? PhM : ext_next(ext_d, 2'd1);
        PhM:  nxt = ext_next(ext_d, 2'd1);
        PhL:  nxt = ext_next(ext_d, 2'd2);
        PhTk: nxt = PhPayload;
        PhPayload: begin
          res.out_byte   = d;
          res.byte_valid = 1'b1;
          nonempty_d     = 1'b1;
          nxt            = PhPayload;
          finish         = (left_d == '0);
        end
      endcase

      done = (phase_d != PhPayload) && (nxt == PhPayload);

      if (done) begin
        // S=1 with partition 0 starts a new frame
        if ((fdb_d & vp8rtp_pkg::DESC_S_MASK) != 8'h00 &&
            (fdb_d & vp8rtp_pkg::DESC_PID_MASK) == 8'h00) begin
          res.frame_discard = nonempty_d;
          nonempty_d        = 1'b0;
          if (left_d < BlW'(vp8rtp_pkg::MIN_FRAME_START)) begin
            res.packet_error = 1'b1;
            nxt              = PhWait;
          end
        end
        if (!res.packet_error) begin
          if (left_d == '0) begin
            finish = 1'b1;
          end else begin
            nxt = PhPayload;
          end
        end
      end else if (nxt != PhPayload && left_d == '0) begin
        // descriptor cut short by the packet end
        res.packet_error = 1'b1;
        nxt              = PhWait;
      end

      if (finish) begin
        nxt = PhWait;
        if (marker_d) begin
          dec_ts_d = cur_ts_d;
          if (nonempty_d) begin
            res.frame_end       = 1'b1;
            res.frame_timestamp = cur_ts_d;
            nonempty_d          = 1'b0;
          end
        end
      end
      phase_d = nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhWait;
      dec_ts_q   <= '0;
      cur_ts_q   <= '0;
      nonempty_q <= 1'b0;
      ext_q      <= '0;
      fdb_q      <= '0;
      left_q     <= '0;
      marker_q   <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      dec_ts_q   <= dec_ts_d;
      cur_ts_q   <= cur_ts_d;
      nonempty_q <= nonempty_d;
      ext_q      <= ext_d;
      fdb_q      <= fdb_d;
      left_q     <= left_d;
      marker_q   <= marker_d;
    end
  end

  assign result_o = res;

endmodule

// ----- src/vp8rtp_checker.sv -----
`include "vp8_rtp_depacketizer_unit_assert.svh"

module vp8rtp_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input vp8rtp_pkg::out_t out_data_o,
  input logic             out_valid_o,
  input logic             out_stall_i
);

  // a held result stays offered
  `VP8_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  // input is only pushed back by a full, stalled result stage
  `VP8_ASSERT_IMPL(a_stall_src, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)

  // a frame byte never comes with an error or a discard
  `VP8_ASSERT_IMPL(a_byte_excl, clk_i, rst_ni, out_valid_o && out_data_o.byte_valid,
                   !out_data_o.packet_error && !out_data_o.frame_discard)

  // timestamp is zero unless a frame ends
  `VP8_ASSERT_IMPL(a_ts_zero, clk_i, rst_ni, out_valid_o && !out_data_o.frame_end,
                   out_data_o.frame_timestamp == '0)

  // an accepted byte always gives a result next cycle
  `VP8_ASSERT_NEXT(a_result, clk_i, rst_ni, in_valid_i && !in_stall_o, out_valid_o)

endmodule

bind vp8_rtp_depacketizer_unit vp8rtp_checker u_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_data_o (out_data_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i)
);

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

// Testbench for vp8_rtp_depacketizer_unit.
// Payload bytes are pushed through the valid/stall input channel from a
// queue; every accepted byte runs through a local depacketizer model that
// predicts the single result it causes. The monitor compares each output
// transfer field by field against the oldest prediction.
module tb_top;
  import vp8rtp_pkg::*;

  localparam int unsigned IDLE_LIMIT = 2000;  // cycles with no transfer at all
  localparam int unsigned ITEM_TARGET = 1750;
  localparam int unsigned CALM_TAIL = 150;    // last bytes sent without idling
  localparam int unsigned LONG_HOLD = 300;    // receiver hold-off length
  localparam int unsigned MAX_REPORTS = 50;

  // Descriptor walk of the local model
  typedef enum logic [3:0] {
    PH_WAIT,
    PH_FIRST,
    PH_EXT,
    PH_PICID,
    PH_PICID_LO,
    PH_TL0,
    PH_TIDKEY,
    PH_PAYLOAD,
    PH_DESC_DONE
  } parse_phase_e;

  typedef struct {
    in_t item;
    bit  drain_first;  // hold this byte back until all results are out
  } rtp_byte_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid;
  logic in_stall_o;
  in_t  in_data;
  logic out_valid_o;
  logic out_stall;
  out_t out_data_o;

  vp8_rtp_depacketizer_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .out_data_o (out_data_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  rtp_byte_t   rtp_byte_q[$];
  out_t        parsed_out_q[$];
  logic [7:0]  pkt_bytes[$];

  int unsigned error_count = 0;
  int unsigned results_seen = 0;
  int unsigned idle_cycles = 0;
  int unsigned n_items = 0;
  bit          drain_done = 1'b0;
  bit          in_fired = 1'b0;  // input transfer at the last rising edge
  bit          calm = 1'b0;      // tail of the run: no idling on either side

  // Model state
  logic [31:0]  dec_ts;
  logic [31:0]  cur_ts;
  logic         frame_open;
  parse_phase_e parse_ph;
  logic [7:0]   ext_flags;
  logic [7:0]   desc0;
  logic [10:0]  remaining;
  logic         mk_latched;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (error_count < MAX_REPORTS)
      $display("[%0t] result %0d: %s got %h want %h", $realtime, results_seen, what, got, want);
    error_count++;
  endtask

  // Descriptor field that follows the one just consumed
  function automatic parse_phase_e next_desc_field(input logic [7:0] flags,
                                                    input parse_phase_e after);
    if (after == PH_EXT && (flags & EXT_I_MASK) != 0) return PH_PICID;
    if (after != PH_TL0 && (flags & EXT_L_MASK) != 0) return PH_TL0;
    if ((flags & EXT_TK_MASK) != 0) return PH_TIDKEY;
    return PH_DESC_DONE;
  endfunction

  // One payload byte in, exactly one result out
  task automatic depacketize_byte(input in_t it, output out_t res);
    parse_phase_e ph;
    parse_phase_e nxt;
    logic         finish;
    logic [7:0]   d;
    res = '0;
    ph = parse_ph;
    nxt = PH_WAIT;
    finish = 1'b0;
    d = it.data_byte;

    if (it.packet_start) begin
      // timestamp change closes the open frame, before any parsing
      if (it.rtp_timestamp != dec_ts) begin
        dec_ts = it.rtp_timestamp;
        if (frame_open) begin
          res.frame_end = 1'b1;
          res.frame_timestamp = cur_ts;
          frame_open = 1'b0;
        end
      end
      cur_ts = it.rtp_timestamp;
      mk_latched = it.marker;
      remaining = (it.packet_length > MAX_PACKET_LENGTH) ? MAX_PACKET_LENGTH[10:0]
                                                         : it.packet_length;
      ph = PH_FIRST;
      if (remaining == 0) begin
        res.packet_error = 1'b1;
        ph = PH_WAIT;
      end
    end

    if (ph != PH_WAIT) begin
      remaining--;
      case (ph)
        PH_FIRST: begin
          desc0 = d;
          ext_flags = '0;
          if ((d & DESC_X_MASK) != 0) nxt = PH_EXT;
          else nxt = PH_DESC_DONE;
        end
        PH_EXT: begin
          ext_flags = d;
          nxt = next_desc_field(d, PH_EXT);
        end
        PH_PICID: begin
          if ((d & PID_M_MASK) != 0) nxt = PH_PICID_LO;
          else nxt = next_desc_field(ext_flags, PH_PICID);
        end
        PH_PICID_LO: nxt = next_desc_field(ext_flags, PH_PICID_LO);
        PH_TL0:      nxt = next_desc_field(ext_flags, PH_TL0);
        PH_TIDKEY:   nxt = PH_DESC_DONE;
        default: begin
          res.out_byte = d;
          res.byte_valid = 1'b1;
          frame_open = 1'b1;
          nxt = PH_PAYLOAD;
          if (remaining == 0) finish = 1'b1;
        end
      endcase

      if (nxt == PH_DESC_DONE) begin
        // partition 0 start drops an unfinished frame
        if ((desc0 & DESC_S_MASK) != 0 && (desc0 & DESC_PID_MASK) == 0) begin
          if (frame_open) res.frame_discard = 1'b1;
          frame_open = 1'b0;
          if (remaining < MIN_FRAME_START) begin
            res.packet_error = 1'b1;
            nxt = PH_WAIT;
          end
        end
        if (!res.packet_error) begin
          if (remaining == 0) finish = 1'b1;
          else nxt = PH_PAYLOAD;
        end
      end else if (nxt != PH_PAYLOAD && remaining == 0) begin
        // packet ran out inside the descriptor
        res.packet_error = 1'b1;
        nxt = PH_WAIT;
      end

      if (finish) begin
        nxt = PH_WAIT;
        if (mk_latched) begin
          dec_ts = cur_ts;
          if (frame_open) begin
            res.frame_end = 1'b1;
            res.frame_timestamp = cur_ts;
            frame_open = 1'b0;
          end
        end
      end
      ph = nxt;
    end
    parse_ph = ph;
  endtask

  // Builds a descriptor into pkt_bytes from byte 0 and the extension byte
  task automatic add_descriptor(input logic [7:0] b0, input logic [7:0] ext,
                                input bit long_pid);
    pkt_bytes.push_back(b0);
    if ((b0 & DESC_X_MASK) != 0) begin
      pkt_bytes.push_back(ext);
      if ((ext & EXT_I_MASK) != 0) begin
        pkt_bytes.push_back({long_pid, 7'($urandom)});
        if (long_pid) pkt_bytes.push_back(8'($urandom));
      end
      if ((ext & EXT_L_MASK) != 0) pkt_bytes.push_back(8'($urandom));
      if ((ext & EXT_TK_MASK) != 0) pkt_bytes.push_back(8'($urandom));
    end
  endtask

  task automatic add_payload(input int n);
    int i;
    for (i = 0; i < n; i++) pkt_bytes.push_back(8'($urandom));
  endtask

  // Mostly small frames, a few short starts and a few long ones
  function automatic int payload_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return $urandom_range(0, 2);
    if (r < 97) return $urandom_range(3, 30);
    return $urandom_range(200, 600);
  endfunction

  // Queues the first n_send bytes of pkt_bytes. Bytes past the first carry
  // random side fields, which the block must ignore.
  task automatic push_packet(input logic [31:0] ts, input logic mk, input int len_field,
                             input int n_send, input bit with_start);
    rtp_byte_t s;
    int k;
    for (k = 0; k < n_send; k++) begin
      s.item.data_byte = pkt_bytes[k];
      s.item.packet_start = with_start && (k == 0);
      s.drain_first = 1'b0;
      if (s.item.packet_start) begin
        s.item.packet_length = len_field[PLEN_W-1:0];
        s.item.rtp_timestamp = ts;
        s.item.marker = mk;
        if (!drain_done && n_items > 900) begin
          s.drain_first = 1'b1;
          drain_done = 1'b1;
        end
      end else begin
        s.item.packet_length = PLEN_W'($urandom);
        s.item.rtp_timestamp = $urandom;
        s.item.marker = 1'($urandom);
      end
      if (with_start && (k == 0 || k < len_field)) n_items++;
      rtp_byte_q.push_back(s);
    end
  endtask

  // Driver: new byte at the falling edge once the previous one transferred
  int unsigned gap_left = 0;
  always @(negedge clk_i) begin
    rtp_byte_t s;
    if (rst_ni) begin
      if (!in_valid || in_fired) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (rtp_byte_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (rtp_byte_q[0].drain_first && parsed_out_q.size() != 0) begin
          // sender pause until the block has emptied
          in_valid <= 1'b0;
        end else begin
          s = rtp_byte_q.pop_front();
          in_data <= s.item;
          in_valid <= 1'b1;
          if (!calm && $urandom_range(0, 19) == 0) gap_left = $urandom_range(1, 12);
        end
      end
    end
  end

  // Receiver stall: random bursts, one long hold-off, none in the tail
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && results_seen >= 400) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD - 1;
        out_stall <= 1'b1;
      end else if (calm) begin
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 12) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Sampling at the rising edge: check outputs, predict accepted inputs
  always @(posedge clk_i) begin
    out_t want;
    out_t got;
    bit   took_in;
    bit   gave_out;
    if (rst_ni) begin
      took_in = in_valid && !in_stall_o;
      gave_out = out_valid_o && !out_stall;
      // output first: a result never belongs to the byte taken this edge
      if (gave_out) begin
        got = out_data_o;
        if (parsed_out_q.size() == 0) begin
          report_mismatch("unexpected result, out_byte", 32'(got.out_byte), 32'h0);
        end else begin
          want = parsed_out_q.pop_front();
          if (got.out_byte !== want.out_byte)
            report_mismatch("out_byte", 32'(got.out_byte), 32'(want.out_byte));
          if (got.byte_valid !== want.byte_valid)
            report_mismatch("byte_valid", 32'(got.byte_valid), 32'(want.byte_valid));
          if (got.frame_end !== want.frame_end)
            report_mismatch("frame_end", 32'(got.frame_end), 32'(want.frame_end));
          if (got.frame_timestamp !== want.frame_timestamp)
            report_mismatch("frame_timestamp", got.frame_timestamp, want.frame_timestamp);
          if (got.frame_discard !== want.frame_discard)
            report_mismatch("frame_discard", 32'(got.frame_discard), 32'(want.frame_discard));
          if (got.packet_error !== want.packet_error)
            report_mismatch("packet_error", 32'(got.packet_error), 32'(want.packet_error));
        end
        results_seen++;
      end
      if (took_in) begin
        depacketize_byte(in_data, want);
        parsed_out_q.push_back(want);
      end
      in_fired = took_in;
      calm = (rtp_byte_q.size() < CALM_TAIL);

      // watchdog on transfer-free cycles
      if (took_in || gave_out) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] ts_run;
    logic [7:0]  b0;
    logic        mk;
    int          nparts;
    int          p;
    int          len;
    int          kind;

    rst_ni = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    dec_ts = '0;
    cur_ts = '0;
    frame_open = 1'b0;
    parse_ph = PH_WAIT;
    ext_flags = '0;
    desc0 = '0;
    remaining = '0;
    mk_latched = 1'b0;

    // Directed part
    // zero length packet, same timestamp as after reset
    pkt_bytes = '{8'h5A};
    push_packet(32'h0, 1'b0, 0, 1, 1'b0 == 1'b0);
    // stray byte while waiting, side fields random
    pkt_bytes = '{8'hFF};
    push_packet(32'hFFFF_FFFF, 1'b1, 2047, 1, 1'b0);
    // minimal frame start, marker closes it with an all-ones timestamp
    pkt_bytes = '{8'h10, 8'h00, 8'hFF, 8'hA5};
    push_packet(32'hFFFF_FFFF, 1'b1, 4, 4, 1'b1);
    // every extension field, 15-bit PictureID
    pkt_bytes = '{8'h90, 8'hF0, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h11, 8'h22, 8'h33};
    push_packet(32'd5, 1'b0, 9, 9, 1'b1);
    // new timestamp ends the open frame
    pkt_bytes = '{8'h00, 8'h44};
    push_packet(32'd6, 1'b0, 2, 2, 1'b1);
    // partition 0 start drops the open frame, then too short
    pkt_bytes = '{8'h10, 8'h77};
    push_packet(32'd6, 1'b0, 2, 2, 1'b1);
    // descriptor cut off inside the extension
    pkt_bytes = '{8'h80, 8'h80};
    push_packet(32'd6, 1'b0, 2, 2, 1'b1);
    // maximum length field, abandoned by an early packet start
    pkt_bytes = '{8'h00, 8'h01, 8'h02};
    push_packet(32'd7, 1'b0, 2047, 3, 1'b1);
    // descriptor-only packet with marker closes the frame
    pkt_bytes = '{8'h00};
    push_packet(32'd7, 1'b1, 1, 1, 1'b1);

    // Random part: mostly well-formed frames, some broken packets
    ts_run = $urandom;
    while (n_items < ITEM_TARGET) begin
      kind = $urandom_range(0, 99);
      if (kind < 80) begin
        nparts = $urandom_range(1, 4);
        if ($urandom_range(0, 3) != 0) ts_run = $urandom;
        for (p = 0; p < nparts; p++) begin
          b0 = 8'($urandom);
          if (p == 0 || $urandom_range(0, 9) == 0) begin
            b0 = (b0 & ~DESC_PID_MASK) | DESC_S_MASK;
          end else if ($urandom_range(0, 1) == 0) begin
            b0 = b0 & ~DESC_S_MASK;
          end else begin
            b0 = b0 | DESC_S_MASK;
            if ((b0 & DESC_PID_MASK) == 0) b0 = b0 | 8'h01;
          end
          if ($urandom_range(0, 3) != 0) b0 = b0 | DESC_X_MASK;
          pkt_bytes.delete();
          add_descriptor(b0, 8'($urandom), 1'($urandom));
          add_payload(payload_len());
          mk = (p == nparts - 1) && ($urandom_range(0, 4) != 0);
          push_packet(ts_run, mk, pkt_bytes.size(), pkt_bytes.size(), 1'b1);
        end
      end else begin
        if ($urandom_range(0, 2) == 0) ts_run = $urandom;
        mk = 1'($urandom);
        pkt_bytes.delete();
        add_descriptor(8'($urandom), 8'($urandom), 1'($urandom));
        add_payload($urandom_range(0, 8));
        case ($urandom_range(0, 4))
          0: begin
            // length of one to three bytes, which may end inside the descriptor
            len = $urandom_range(1, 3);
            if (len > pkt_bytes.size()) len = pkt_bytes.size();
            push_packet(ts_run, mk, len, len, 1'b1);
          end
          1: begin
            // length field longer than what is sent: next start cuts it
            len = pkt_bytes.size() + $urandom_range(1, 2047 - pkt_bytes.size());
            push_packet(ts_run, mk, len, pkt_bytes.size(), 1'b1);
          end
          2: begin
            // length field shorter: trailing bytes arrive as strays
            len = $urandom_range(1, pkt_bytes.size());
            push_packet(ts_run, mk, len, pkt_bytes.size(), 1'b1);
          end
          3: push_packet(ts_run, mk, 0, pkt_bytes.size(), 1'b1);
          default: push_packet(ts_run, mk, 0, $urandom_range(1, 3), 1'b0);
        endcase
      end
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (rtp_byte_q.size() != 0 || in_valid) @(posedge clk_i);
    while (parsed_out_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+src
src/vp8rtp_pkg.sv
src/vp8rtp_core.sv
src/vp8_rtp_depacketizer_unit.sv
src/vp8rtp_checker.sv
verif/tb_top.sv
